// File: src/stepper_focuser_sequencer_defines.svh
// Assertion helpers shared by the sequencer RTL.
// Both expect aclk and aresetn in scope.
`ifndef STEPPER_FOCUSER_SEQUENCER_DEFINES_SVH
`define STEPPER_FOCUSER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sfs_pkg.sv
`default_nettype none
package sfs_pkg;

    localparam int POSITION_BITS_DEF = 8;
    localparam int REV_BITS          = 8;
    localparam int FSPR_BITS         = 7;
    localparam int COUNT_BITS        = 7;
    localparam int OUT_POS_BITS      = 8;

    localparam logic [FSPR_BITS-1:0] FSPR_RESET = 7'd48;
    localparam logic [FSPR_BITS-1:0] FSPR_MIN   = 7'd2;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_FSPR = 1'b0;

    // encoder levels {b, a}
    localparam logic [1:0] ENC_LVL_A = 2'b10;
    localparam logic [1:0] ENC_LVL_B = 2'b11;

    typedef enum logic [2:0] {
        REQ_ENCODER = 3'd0,
        REQ_MARK    = 3'd1,
        REQ_CENTER  = 3'd2,
        REQ_MODE    = 3'd3,
        REQ_TICK    = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_FWD  = 2'd1,
        MOVE_BACK = 2'd2
    } enc_move_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

    // result beat, msb first; packs into m_tdata[30:0]
    typedef struct packed {
        enc_move_t                encoder_move;
        logic [COUNT_BITS-1:0]    steps_left;
        logic                     moving;
        logic                     half_step_mode;
        logic [OUT_POS_BITS-1:0]  mark_position;
        logic [OUT_POS_BITS-1:0]  position;
        logic [3:0]               coil_drive;
    } result_t;

    function automatic logic [3:0] full_coil(input logic [1:0] ph);
        logic [3:0] c;
        case (ph)
            2'd0:    c = 4'b0101;
            2'd1:    c = 4'b1001;
            2'd2:    c = 4'b1010;
            default: c = 4'b0110;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] half_coil(input logic [2:0] ph);
        logic [3:0] c;
        case (ph)
            3'd0:    c = 4'b0101;
            3'd1:    c = 4'b0001;
            3'd2:    c = 4'b1001;
            3'd3:    c = 4'b1000;
            3'd4:    c = 4'b1010;
            3'd5:    c = 4'b0010;
            3'd6:    c = 4'b0110;
            default: c = 4'b0100;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/sfs_rem_unit.sv
`default_nettype none
`include "stepper_focuser_sequencer_defines.svh"
module sfs_rem_unit #(
    parameter int DIVIDEND_BITS = sfs_pkg::POSITION_BITS_DEF + 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [DIVIDEND_BITS-1:0]           dividend,
    input  wire logic [sfs_pkg::REV_BITS-1:0]       divisor,
    output sfs_pkg::rem_status_t                    status,
    output logic      [sfs_pkg::REV_BITS-1:0]       result
);
    import sfs_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] shift_reg;
    logic [REV_BITS-1:0]      rem_reg;
    logic [REV_BITS-1:0]      div_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [REV_BITS:0]        trial;
    logic [REV_BITS:0]        trial_sub;
    logic [REV_BITS-1:0]      rem_next;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial     = {rem_reg, shift_reg[DIVIDEND_BITS-1]};
        trial_sub = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = trial_sub[REV_BITS-1:0];
        end else begin
            rem_next = trial[REV_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[DIVIDEND_BITS-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = rem_reg;

    `SFS_ASSERT_IMP(a_rem_in_range, done_reg, rem_reg < div_reg, "remainder not below divisor")
    `SFS_ASSERT_NXT(a_start_goes_busy, start, busy_reg && !done_reg, "start did not raise busy")
    `SFS_ASSERT_NXT(a_done_single, done_reg, !done_reg, "done held longer than a cycle")

endmodule
`default_nettype wire

// File: src/stepper_focuser_sequencer.sv
// Results are registered in a two-deep output buffer: an output register and a skid register.
// Throughput: one beat per cycle unless the skid is full; input stays open while a result waits.
// A step landing at or beyond twice the revolution (only after a register write) runs a
// serial remainder: input is held off while it runs and the beat is pushed when it is done.
// Reset: synchronous active-low aresetn clears control state, not payloads; fspr_reg gets 48.
`default_nettype none
`include "stepper_focuser_sequencer_defines.svh"
module stepper_focuser_sequencer #(
    parameter int POSITION_BITS = sfs_pkg::POSITION_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] enc_a, [1] enc_b, rest zero
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [3:0] coil_drive, [11:4] position,
                                        // [19:12] mark_position, [20] half_step_mode,
                                        // [21] moving, [28:22] steps_left,
                                        // [30:29] encoder_move, [31] zero
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sfs_pkg::*;

    localparam int PW = POSITION_BITS + 1;

    // ---------------------------------------------------------------
    // Register port: single register, write at access phase
    // ---------------------------------------------------------------
    logic [FSPR_BITS-1:0] fspr_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_FSPR);
    assign prdata = (paddr[2] == CFG_IDX_FSPR) ? {25'd0, fspr_reg} : 32'd0;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [2:0]               phase_reg,  phase_next;
    logic [POSITION_BITS-1:0] rotor_reg,  rotor_next;
    logic [POSITION_BITS-1:0] mark_reg,   mark_next;
    logic                     half_reg,   half_next;
    logic [1:0]               last_reg,   last_next;
    logic [COUNT_BITS-1:0]    mc_reg,     mc_next;
    logic                     mback_reg,  mback_next;

    result_t                  pend_reg;
    result_t                  out_reg;
    logic                     out_valid_reg;
    result_t                  skid_reg;
    logic                     skid_valid_reg;

    // ---------------------------------------------------------------
    // Remainder unit handles the rare wide-out-of-range step
    // ---------------------------------------------------------------
    rem_status_t          rem_status;
    logic [REV_BITS-1:0]  rem_result;
    logic                 rem_start;

    req_t                 req;
    logic                 s_accept;
    logic [1:0]           enc_now;

    // revolution length of the active mode
    logic [FSPR_BITS-1:0] rev_base;
    logic [REV_BITS-1:0]  rev8;
    logic [PW-1:0]        rev_w;
    logic [PW-1:0]        rev2_w;

    // stepping
    logic                 do_step;
    logic                 step_back;
    logic [2:0]           ph_step;
    logic [PW-1:0]        v_step;
    logic [PW-1:0]        pos_w;
    logic                 step_fast;
    logic                 slow_needed;
    enc_move_t            enc_move;

    // center move
    logic [POSITION_BITS-1:0] ctr_diff;
    logic                     ctr_back;
    logic [PW-1:0]            ctr_flip;
    logic [COUNT_BITS-1:0]    ctr_count;
    logic                     ctr_back_final;

    result_t              res_now;
    result_t              res_slow;
    result_t              push_data;
    logic                 push;
    logic                 pop;

    assign req      = req_t'(s_tuser);
    assign enc_now  = {s_tdata[1], s_tdata[0]};
    assign s_tready = !rem_status.busy && !rem_status.done && !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    // register values below two behave as two
    always_comb begin
        rev_base = (fspr_reg < FSPR_MIN) ? FSPR_MIN : fspr_reg;
        rev8     = half_reg ? {rev_base, 1'b0} : {1'b0, rev_base};
        rev_w    = {{(PW-REV_BITS){1'b0}}, rev8};
        rev2_w   = rev_w << 1;
    end

    // one step in either direction; forward counts down
    always_comb begin
        if (step_back) begin
            ph_step = phase_reg + 3'd1;
            v_step  = {1'b0, rotor_reg} + PW'(1);
        end else begin
            ph_step = phase_reg - 3'd1;
            v_step  = {1'b0, rotor_reg} - PW'(1);
        end
        if (!half_reg) begin
            ph_step[2] = 1'b0;
        end

        step_fast = 1'b1;
        if (!step_back && (rotor_reg == '0)) begin
            pos_w = rev_w - PW'(1);
        end else if (v_step < rev_w) begin
            pos_w = v_step;
        end else if (v_step < rev2_w) begin
            pos_w = v_step - rev_w;
        end else begin
            // far beyond the revolution: serial remainder
            pos_w     = v_step;
            step_fast = 1'b0;
        end
    end

    // shortest wrapped distance to the mark, halved
    always_comb begin
        if (rotor_reg >= mark_reg) begin
            ctr_diff = rotor_reg - mark_reg;
            ctr_back = 1'b0;
        end else begin
            ctr_diff = mark_reg - rotor_reg;
            ctr_back = 1'b1;
        end
        ctr_flip = rev_w - {1'b0, ctr_diff};
        if ({1'b0, ctr_diff} > (rev_w >> 1)) begin
            ctr_back_final = !ctr_back;
            // a stale mark may put the distance past a revolution: no move then
            if (!ctr_flip[PW-1] && (ctr_flip != '0)) begin
                ctr_count = ctr_flip[COUNT_BITS:1];
            end else begin
                ctr_count = '0;
            end
        end else begin
            ctr_back_final = ctr_back;
            ctr_count      = ctr_diff[COUNT_BITS:1];
        end
    end

    // next state for the accepted beat
    always_comb begin
        phase_next = phase_reg;
        rotor_next = rotor_reg;
        mark_next  = mark_reg;
        half_next  = half_reg;
        last_next  = last_reg;
        mc_next    = mc_reg;
        mback_next = mback_reg;
        enc_move   = MOVE_NONE;
        do_step    = 1'b0;
        step_back  = 1'b0;

        if (mc_reg != '0) begin
            // move under way: only ticks count
            if (req == REQ_TICK) begin
                mc_next   = mc_reg - 1'b1;
                do_step   = 1'b1;
                step_back = mback_reg;
            end
        end else begin
            case (req)
                REQ_ENCODER: begin
                    if ((last_reg == ENC_LVL_A) && (enc_now == ENC_LVL_B)) begin
                        enc_move = MOVE_FWD;
                    end else if ((last_reg == ENC_LVL_B) && (enc_now == ENC_LVL_A)) begin
                        enc_move = MOVE_BACK;
                    end
                    last_next = enc_now;
                    do_step   = (enc_move != MOVE_NONE);
                    step_back = (enc_move == MOVE_BACK);
                end
                REQ_MARK: begin
                    mark_next = rotor_reg;
                end
                REQ_CENTER: begin
                    mback_next = ctr_back_final;
                    mc_next    = ctr_count;
                end
                REQ_MODE: begin
                    if (half_reg) begin
                        half_next  = 1'b0;
                        phase_next = phase_reg >> 1;
                        rotor_next = rotor_reg >> 1;
                    end else begin
                        half_next  = 1'b1;
                        phase_next = {phase_reg[1:0], 1'b0};
                        rotor_next = rotor_reg << 1;
                    end
                end
                default: begin
                    // tick with no move, or unused code: nothing changes
                end
            endcase
        end

        if (do_step) begin
            phase_next = ph_step;
            if (step_fast) begin
                rotor_next = pos_w[POSITION_BITS-1:0];
            end
        end
    end

    assign slow_needed = do_step && !step_fast;
    assign rem_start   = s_accept && slow_needed;

    sfs_rem_unit #(
        .DIVIDEND_BITS (PW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (v_step),
        .divisor  (rev8),
        .status   (rem_status),
        .result   (rem_result)
    );

    // result fields, taken after the update
    always_comb begin
        res_now.coil_drive     = half_next ? half_coil(phase_next)
                                           : full_coil(phase_next[1:0]);
        res_now.position       = rotor_next[OUT_POS_BITS-1:0];
        res_now.mark_position  = mark_next[OUT_POS_BITS-1:0];
        res_now.half_step_mode = half_next;
        res_now.moving         = (mc_next != '0);
        res_now.steps_left     = mc_next;
        res_now.encoder_move   = enc_move;

        res_slow          = pend_reg;
        res_slow.position = rem_result[OUT_POS_BITS-1:0];
    end

    assign push      = (s_accept && !slow_needed) || rem_status.done;
    assign push_data = rem_status.done ? res_slow : res_now;
    assign pop       = out_valid_reg && m_tready;

    // ---------------------------------------------------------------
    // Control and state registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fspr_reg       <= FSPR_RESET;
            phase_reg      <= '0;
            rotor_reg      <= '0;
            mark_reg       <= '0;
            half_reg       <= 1'b0;
            last_reg       <= '0;
            mc_reg         <= '0;
            mback_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                fspr_reg <= pwdata[FSPR_BITS-1:0];
            end
            if (s_accept) begin
                phase_reg <= phase_next;
                rotor_reg <= rotor_next;
                mark_reg  <= mark_next;
                half_reg  <= half_next;
                last_reg  <= last_next;
                mc_reg    <= mc_next;
                mback_reg <= mback_next;
            end
            if (rem_status.done) begin
                rotor_reg <= POSITION_BITS'(rem_result);
            end

            // output buffer: a push only lands while the skid slot is free
            if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (out_valid_reg && !pop && push) begin
                skid_valid_reg <= 1'b1;
            end
            if (skid_valid_reg) begin
                if (pop) begin
                    out_valid_reg <= 1'b1;
                end
            end else if (!out_valid_reg || pop) begin
                out_valid_reg <= push;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rem_start) begin
            pend_reg <= res_now;
        end
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || pop) begin
            if (push) begin
                out_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    `SFS_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid beat without output beat")
    `SFS_ASSERT_IMP(a_hold_during_rem, rem_status.busy || rem_status.done, !s_tready, "input open during remainder")
    `SFS_ASSERT_NXT(a_move_ignores_events, s_accept && (mc_reg != '0) && (req != REQ_TICK), $stable(rotor_reg) && $stable(mc_reg), "event changed state during a move")
    `SFS_ASSERT_IMP(a_done_has_room, rem_status.done, !skid_valid_reg, "remainder result with no buffer slot")

endmodule
`default_nettype wire
